// ----- rtl/nnvo_pkg.sv -----
// Shared types and constants for the nearest-neighbor visit order block.
package nnvo_pkg;

   localparam int COORD_BITS     = 10;
   localparam int POT_BITS       = 8;
   localparam int DIST_BITS      = 11;
   localparam int MAX_POINTS_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int SQ_BITS        = 2 * COORD_BITS + 1;
   localparam int LIM_BITS       = 2 * DIST_BITS;
   localparam int CMP_BITS       = (LIM_BITS > SQ_BITS) ? LIM_BITS : SQ_BITS;

   localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(1000);

   localparam logic CMD_MOVE = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [POT_BITS-1:0]   pot_type;

   typedef struct packed {
      logic      cmd;
      coord_type pos_x;
      coord_type pos_y;
      pot_type   pot_id;
      logic      load_end;
   } req_type;

   typedef struct packed {
      pot_type   visit_index;
      coord_type visit_x;
      coord_type visit_y;
      logic      tour_end;
   } rsp_type;

   // Classified work for the back end
   typedef enum logic [1:0] {
      OP_MOVE = 2'd0,
      OP_LOAD = 2'd1,
      OP_RUN  = 2'd2
   } op_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      pot_type   id;
   } point_type;

   typedef struct packed {
      op_type    op;
      point_type pt;
   } work_type;

endpackage

// ----- rtl/nnvo_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
module nnvo_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nnvo_pkg::req_type  req_data,
   output logic               q_valid,
   input  logic               q_pop,
   output nnvo_pkg::work_type q_head
);
   import nnvo_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   work_type              work_in;
   logic                  push, pop;

   assign req_ready = (fill_ff != CNT_BITS'(QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_head    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      work_in.pt.x  = req_data.pos_x;
      work_in.pt.y  = req_data.pos_y;
      work_in.pt.id = req_data.pot_id;
      if (req_data.cmd == CMD_MOVE) begin
         work_in.op = OP_MOVE;
      end else if (req_data.load_end) begin
         work_in.op = OP_RUN;
      end else begin
         work_in.op = OP_LOAD;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= work_in;
      end
   end

endmodule

// ----- rtl/nnvo_back.sv -----
// Back end: point store, nearest-point scan pipeline and result register.
module nnvo_back #(
   parameter int MAX_POINTS = nnvo_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  nnvo_pkg::work_type              q_head,
   input  logic [nnvo_pkg::DIST_BITS-1:0]  max_distance,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nnvo_pkg::rsp_type               rsp_data
);
   import nnvo_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_POINTS);
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
   localparam int PRD_BITS = 2 * COORD_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // control
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   rd_cnt_ff, rd_cnt_in;
   coord_type             here_x_ff, here_x_in;
   coord_type             here_y_ff, here_y_in;
   logic [CMP_BITS-1:0]   best_ff, best_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   pick_ff, pick_in;
   point_type             pick_pt_ff, pick_pt_in;
   logic                  pend_vld_ff, pend_vld_in;
   point_type             pend_pt_ff, pend_pt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [LIM_BITS-1:0]   lim_ff, lim_in;

   // point store
   point_type             store_mem [MAX_POINTS];
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   point_type             wr_pt;
   logic                  issue;

   // scan pipeline
   point_type             rd_data_ff;
   logic                  s1_vld_ff, s1_last_ff;
   logic [IDX_BITS-1:0]   s1_idx_ff;
   logic                  s2_vld_ff;
   logic [IDX_BITS-1:0]   s2_idx_ff;
   point_type             s2_pt_ff;
   coord_type             dx_ff, dy_ff;
   logic                  s3_vld_ff;
   logic [IDX_BITS-1:0]   s3_idx_ff;
   point_type             s3_pt_ff;
   logic [PRD_BITS-1:0]   sqx_ff, sqy_ff;
   point_type             last_pt_ff;
   logic [SQ_BITS-1:0]    dist_sq;
   logic                  out_free;

   assign issue     = (state_ff == ST_SCAN) && (rd_cnt_ff < count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dist_sq   = SQ_BITS'(sqx_ff) + SQ_BITS'(sqy_ff);
   assign lim_in    = LIM_BITS'(max_distance) * LIM_BITS'(max_distance);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_cnt_in    = rd_cnt_ff;
      here_x_in    = here_x_ff;
      here_y_in    = here_y_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_pt_in   = pick_pt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_pt_in   = pend_pt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pick_ff;
      wr_pt        = last_pt_ff;
      q_pop        = 1'b0;

      // compare stage: strict less keeps the lower slot on ties
      if (s3_vld_ff && (CMP_BITS'(dist_sq) < best_ff)) begin
         best_in    = CMP_BITS'(dist_sq);
         found_in   = 1'b1;
         pick_in    = s3_idx_ff;
         pick_pt_in = s3_pt_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               case (q_head.op)
                  OP_MOVE: begin
                     here_x_in = q_head.pt.x;
                     here_y_in = q_head.pt.y;
                  end
                  OP_LOAD, OP_RUN: begin
                     if (count_ff < CNT_BITS'(MAX_POINTS)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_BITS-1:0];
                        wr_pt    = q_head.pt;
                        count_in = count_ff + 1'b1;
                     end
                     if (q_head.op == OP_RUN) begin
                        rd_cnt_in = '0;
                        best_in   = CMP_BITS'(lim_ff);
                        found_in  = 1'b0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               state_in = ST_FINISH;
            end else if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{pend_pt_ff.id, pend_pt_ff.x, pend_pt_ff.y, 1'b0};
               end
               pend_vld_in = 1'b1;
               pend_pt_in  = pick_pt_ff;
               here_x_in   = pick_pt_ff.x;
               here_y_in   = pick_pt_ff.y;
               // swap-remove: last slot moves into the chosen slot
               wr_en       = 1'b1;
               wr_addr     = pick_ff;
               wr_pt       = last_pt_ff;
               count_in    = count_ff - 1'b1;
               rd_cnt_in   = '0;
               best_in     = CMP_BITS'(lim_ff);
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{pend_pt_ff.id, pend_pt_ff.x, pend_pt_ff.y, 1'b1};
               end
               pend_vld_in = 1'b0;
               count_in    = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         here_x_ff    <= '0;
         here_y_ff    <= '0;
         found_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         here_x_ff    <= here_x_in;
         here_y_ff    <= here_y_in;
         found_ff     <= found_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= issue;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      pick_pt_ff  <= pick_pt_in;
      pend_pt_ff  <= pend_pt_in;
      rsp_data_ff <= rsp_data_in;
      lim_ff      <= lim_in;
   end

   // point store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_pt;
      end
      if (issue) begin
         rd_data_ff <= store_mem[rd_cnt_ff[IDX_BITS-1:0]];
      end
   end

   // scan pipeline: read, abs difference, squares, compare
   always_ff @(posedge clock) begin
      s1_idx_ff  <= rd_cnt_ff[IDX_BITS-1:0];
      s1_last_ff <= (rd_cnt_ff == count_ff - 1'b1);
      if (s1_vld_ff && s1_last_ff) begin
         last_pt_ff <= rd_data_ff;
      end
      s2_idx_ff <= s1_idx_ff;
      s2_pt_ff  <= rd_data_ff;
      dx_ff     <= (rd_data_ff.x > here_x_ff) ? rd_data_ff.x - here_x_ff
                                              : here_x_ff - rd_data_ff.x;
      dy_ff     <= (rd_data_ff.y > here_y_ff) ? rd_data_ff.y - here_y_ff
                                              : here_y_ff - rd_data_ff.y;
      s3_idx_ff <= s2_idx_ff;
      s3_pt_ff  <= s2_pt_ff;
      sqx_ff    <= PRD_BITS'(dx_ff) * PRD_BITS'(dx_ff);
      sqy_ff    <= PRD_BITS'(dy_ff) * PRD_BITS'(dy_ff);
   end

endmodule

// ----- rtl/nearest_neighbor_visit_order_top.sv -----
// Top level: nearest-neighbor visit ordering with a queued front end.
// A move or load item is retired as the back end, while idle, takes it from the two-entry
// queue. A tour emits one point per scan of the stored points, through a registered read
// and a distance pipeline of abs difference, squares and compare. Reset (synchronous,
// active high) empties the queue and store count, zeroes the position and sets
// max_distance to 1000.
module nearest_neighbor_visit_order_top #(
   parameter int MAX_POINTS = nnvo_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nnvo_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nnvo_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [nnvo_pkg::DIST_BITS-1:0]  csr_wdata
);
   import nnvo_pkg::*;

   // distance limit register; the user must write it only while the block is idle (not enforced here)
   logic [DIST_BITS-1:0] max_dist_ff, max_dist_in;

   // queue head between front and back
   logic     q_valid;
   logic     q_pop;
   work_type q_head;

   assign max_dist_in = csr_we ? csr_wdata : max_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= DIST_RESET;
      end else begin
         max_dist_ff <= max_dist_in;
      end
   end

   // front end classifies each item as move, load, or load-and-run
   nnvo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head)
   );

   // back end holds the points, scans for the nearest one and emits each visited point;
   // the last visited point is held back until the next scan shows whether it ends the tour
   nnvo_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_head       (q_head),
      .max_distance (max_dist_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
